[design/tcpa_pkg.sv]
// Shared types, constants and command codes of the complex projection accumulator.
package tcpa_pkg;

	// Lattice extents; index fields are concatenated into the store address.
	localparam int MAX_TIME    = 64;
	localparam int MAX_VECTORS = 128;
	localparam int SPINS       = 4;
	localparam int TIME_W      = 6;
	localparam int VEC_W       = 7;
	localparam int SPIN_W      = 2;
	localparam int ADDR_W      = TIME_W + VEC_W + SPIN_W;
	localparam int DEPTH       = MAX_TIME * MAX_VECTORS * SPINS;

	// Data widths.
	localparam int IN_W    = 16;
	localparam int MUL_W   = 2 * IN_W;
	localparam int PROD_W  = MUL_W + 1;
	localparam int ACC_W   = 48;
	localparam int WORD_W  = 2 * ACC_W + 1;

	// Configuration register widths, reset values and indexes.
	localparam int NTS_W  = 7;
	localparam int NVEC_W = 8;
	localparam logic [NTS_W-1:0]  NUM_TS_RESET  = NTS_W'(MAX_TIME);
	localparam logic [NVEC_W-1:0] NUM_VEC_RESET = NVEC_W'(MAX_VECTORS);
	localparam logic REG_NUM_TS  = 1'b0;
	localparam logic REG_NUM_VEC = 1'b1;

	// Command codes.
	localparam logic [1:0] CMD_ACC      = 2'd0;
	localparam logic [1:0] CMD_READ     = 2'd1;
	localparam logic [1:0] CMD_READ_CLR = 2'd2;
	localparam logic [1:0] CMD_NONE     = 2'd3;

	// Saturation limits of one accumulator part.
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Work queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = QPTR_W + 1;

	// One classified item waiting for the back.
	typedef struct packed {
		logic                     bad;
		logic [1:0]               cmd;
		logic [ADDR_W-1:0]        addr;
		logic signed [PROD_W-1:0] pre;
		logic signed [PROD_W-1:0] pim;
	} q_entry_t;

	// Back state machine.
	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EXEC
	} back_state_t;

endpackage

[design/tcpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/tcpa_front.sv]
// Front end: accepts commands, checks indexes, forms the conjugate product.
module tcpa_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [1:0]                         command,
	input  logic [tcpa_pkg::TIME_W-1:0]        time_slice,
	input  logic [tcpa_pkg::VEC_W-1:0]         vector_index,
	input  logic [tcpa_pkg::SPIN_W-1:0]        spin_index,
	input  logic signed [tcpa_pkg::IN_W-1:0]   sol_re,
	input  logic signed [tcpa_pkg::IN_W-1:0]   sol_im,
	input  logic signed [tcpa_pkg::IN_W-1:0]   vec_re,
	input  logic signed [tcpa_pkg::IN_W-1:0]   vec_im,
	input  logic [tcpa_pkg::NTS_W-1:0]         num_ts,
	input  logic [tcpa_pkg::NVEC_W-1:0]        num_vec,
	output logic                               pending,
	output logic                               push,
	output tcpa_pkg::q_entry_t                 push_entry
);

	import tcpa_pkg::*;

	logic                    v_s1;
	logic [1:0]              cmd_s1;
	logic                    bad_s1;
	logic [ADDR_W-1:0]       addr_s1;
	logic signed [MUL_W-1:0] p_ac_s1;
	logic signed [MUL_W-1:0] p_bd_s1;
	logic signed [MUL_W-1:0] p_bc_s1;
	logic signed [MUL_W-1:0] p_ad_s1;
	logic                    idx_ok;

	// An index is valid only inside both the configured and the built extent.
	assign idx_ok = (NTS_W'(time_slice) < num_ts) && (32'(time_slice) < MAX_TIME) &&
		(NVEC_W'(vector_index) < num_vec) && (32'(vector_index) < MAX_VECTORS) &&
		(32'(spin_index) < SPINS);

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// Stage payload: classification and the four partial products.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			bad_s1  <= !idx_ok;
			addr_s1 <= {time_slice, vector_index, spin_index};
			p_ac_s1 <= sol_re * vec_re;
			p_bd_s1 <= sol_im * vec_im;
			p_bc_s1 <= sol_im * vec_re;
			p_ad_s1 <= sol_re * vec_im;
		end
	end

	// CMD_NONE commands are dropped here and never reach the queue.
	assign pending = v_s1;
	assign push    = v_s1 && (cmd_s1 != CMD_NONE);

	always_comb begin
		push_entry.bad  = bad_s1;
		push_entry.cmd  = cmd_s1;
		push_entry.addr = addr_s1;
		push_entry.pre  = PROD_W'(p_ac_s1) + PROD_W'(p_bd_s1);
		push_entry.pim  = PROD_W'(p_bc_s1) - PROD_W'(p_ad_s1);
	end

endmodule

[design/tcpa_queue.sv]
// Short FIFO that decouples the front end from the store sequencer.
module tcpa_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  tcpa_pkg::q_entry_t          push_entry,
	input  logic                        pop,
	output tcpa_pkg::q_entry_t          head,
	output logic                        empty,
	output logic [tcpa_pkg::QCNT_W-1:0] count
);

	import tcpa_pkg::*;

	q_entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

[design/tcpa_back.sv]
// Back end: clears the store after reset, then reads each good item's entry and writes it back per command.
module tcpa_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tcpa_pkg::q_entry_t                head,
	input  logic                              empty,
	output logic                              pop,
	output logic                              clearing,
	output logic                              done,
	output logic signed [tcpa_pkg::ACC_W-1:0] acc_re,
	output logic signed [tcpa_pkg::ACC_W-1:0] acc_im,
	output logic                              saturated,
	output logic                              bad_index
);

	import tcpa_pkg::*;

	back_state_t             state_q;
	back_state_t             state_d;
	logic [ADDR_W-1:0]       clr_cnt_q;
	q_entry_t                op_q;
	logic                    done_q;
	logic signed [ACC_W-1:0] acc_re_q;
	logic signed [ACC_W-1:0] acc_im_q;
	logic                    sat_q;
	logic                    bad_q;

	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [WORD_W-1:0]       ram_wdata;
	logic                    ram_re;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [WORD_W-1:0]       ram_rdata;

	logic                    rd_sat;
	logic signed [ACC_W-1:0] rd_re;
	logic signed [ACC_W-1:0] rd_im;
	logic signed [ACC_W:0]   sum_re;
	logic signed [ACC_W:0]   sum_im;
	logic signed [ACC_W-1:0] new_re;
	logic signed [ACC_W-1:0] new_im;
	logic                    hit_re;
	logic                    hit_im;
	logic                    is_acc;
	logic                    is_read;

	tcpa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Unpack the entry read from the store.
	assign rd_sat = ram_rdata[WORD_W-1];
	assign rd_re  = ram_rdata[2*ACC_W-1:ACC_W];
	assign rd_im  = ram_rdata[ACC_W-1:0];

	// Saturating add of the product into each part.
	assign sum_re = (ACC_W+1)'(rd_re) + (ACC_W+1)'(op_q.pre);
	assign sum_im = (ACC_W+1)'(rd_im) + (ACC_W+1)'(op_q.pim);
	assign hit_re = sum_re[ACC_W] != sum_re[ACC_W-1];
	assign hit_im = sum_im[ACC_W] != sum_im[ACC_W-1];
	assign new_re = hit_re ? (sum_re[ACC_W] ? ACC_MIN : ACC_MAX) : sum_re[ACC_W-1:0];
	assign new_im = hit_im ? (sum_im[ACC_W] ? ACC_MIN : ACC_MAX) : sum_im[ACC_W-1:0];

	assign is_acc  = (op_q.cmd == CMD_ACC);
	assign is_read = (op_q.cmd == CMD_READ) || (op_q.cmd == CMD_READ_CLR);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!empty && !head.bad) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_CLEAR;
			end
		endcase
	end

	// Store and queue controls.
	always_comb begin
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = op_q.addr;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = head.addr;
		case (state_q)
			BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
			end
			BK_IDLE: begin
				pop    = !empty;
				ram_re = !empty && !head.bad;
			end
			BK_EXEC: begin
				ram_we = is_acc || (op_q.cmd == CMD_READ_CLR);
				if (is_acc) begin
					ram_wdata = {rd_sat | hit_re | hit_im, new_re, new_im};
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// State and clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((state_q == BK_IDLE) && !empty && head.bad) ||
				((state_q == BK_EXEC) && is_read);
		end
	end

	// Operation register and result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head;
		end
		if ((state_q == BK_IDLE) && !empty && head.bad) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
			sat_q    <= 1'b0;
			bad_q    <= 1'b1;
		end else if (state_q == BK_EXEC) begin
			acc_re_q <= rd_re;
			acc_im_q <= rd_im;
			sat_q    <= rd_sat;
			bad_q    <= 1'b0;
		end
	end

	assign clearing  = (state_q == BK_CLEAR);
	assign done      = done_q;
	assign acc_re    = acc_re_q;
	assign acc_im    = acc_im_q;
	assign saturated = sat_q;
	assign bad_index = bad_q;

endmodule

[design/timeslice_complex_projection_accum.sv]
// A command passes the front-end stage register, the queue and the sequencer's idle
// and execute states; a read returns its beat from the result register, a bad index
// skipping execute. Good items read the registered-read accumulator RAM and write back
// per command; a 4-entry queue lets start be taken while the sequencer works. Results
// cannot be stalled. Reset: asynchronous; then all 32768 entries are zeroed, busy high.
// Configuration registers are readable and writable at any time.
module timeslice_complex_projection_accum (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        command,
	input  logic [tcpa_pkg::TIME_W-1:0]       time_slice,
	input  logic [tcpa_pkg::VEC_W-1:0]        vector_index,
	input  logic [tcpa_pkg::SPIN_W-1:0]       spin_index,
	input  logic signed [tcpa_pkg::IN_W-1:0]  sol_re,
	input  logic signed [tcpa_pkg::IN_W-1:0]  sol_im,
	input  logic signed [tcpa_pkg::IN_W-1:0]  vec_re,
	input  logic signed [tcpa_pkg::IN_W-1:0]  vec_im,
	output logic                              done,
	output logic signed [tcpa_pkg::ACC_W-1:0] acc_re,
	output logic signed [tcpa_pkg::ACC_W-1:0] acc_im,
	output logic                              saturated,
	output logic                              bad_index,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	import tcpa_pkg::*;

	logic [NTS_W-1:0]  num_ts_q;
	logic [NVEC_W-1:0] num_vec_q;
	logic              cfg_wr;
	logic              accept;
	logic              pending;
	logic              push;
	q_entry_t          push_entry;
	q_entry_t          head;
	logic              empty;
	logic              pop;
	logic [QCNT_W-1:0] q_count;
	logic              clearing;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ts_q  <= NUM_TS_RESET;
			num_vec_q <= NUM_VEC_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_NUM_TS) begin
				num_ts_q <= pwdata[NTS_W-1:0];
			end else begin
				num_vec_q <= pwdata[NVEC_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_NUM_VEC) ? 32'(num_vec_q) : 32'(num_ts_q);

	// Take a command only after clearing and when the queue has room for it and the item in flight.
	assign busy   = clearing ||
		((QCNT_W+1)'(q_count) + (QCNT_W+1)'(pending) >= (QCNT_W+1)'(QDEPTH));
	assign accept = start && !busy;

	tcpa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (command),
		.time_slice   (time_slice),
		.vector_index (vector_index),
		.spin_index   (spin_index),
		.sol_re       (sol_re),
		.sol_im       (sol_im),
		.vec_re       (vec_re),
		.vec_im       (vec_im),
		.num_ts       (num_ts_q),
		.num_vec      (num_vec_q),
		.pending      (pending),
		.push         (push),
		.push_entry   (push_entry)
	);

	tcpa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.count      (q_count)
	);

	tcpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.clearing  (clearing),
		.done      (done),
		.acc_re    (acc_re),
		.acc_im    (acc_im),
		.saturated (saturated),
		.bad_index (bad_index)
	);

endmodule
